@@ rtl/gsps_pkg.sv @@
// Shared types, constants and helper functions for the game-pad poll sequencer.
`default_nettype none

package gsps_pkg;

  // Sizes
  localparam int MAX_HALFWORDS = 16;
  localparam int PAYLOAD_BYTES = 6;
  localparam int HW_W          = 5;   // halfword count, 1..16
  localparam int IDX_W         = 6;   // byte index within the data phase
  localparam int LEN_W         = 3;   // payload length field
  localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int KEEP_BYTES    = 6;   // data bytes kept: buttons and two axis halfwords

  // Protocol bytes
  localparam logic [7:0] BYTE_HEADER = 8'h01;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_PAD    = 8'hFF;
  localparam logic [7:0] SIGN_FLIP   = 8'h80;
  localparam logic [3:0] COUNT_MASK  = 4'hF;

  // Dead-zone register reset values and indexes
  localparam logic [7:0] DZ_LOW_RST  = 8'h60;
  localparam logic [7:0] DZ_HIGH_RST = 8'hA0;
  localparam logic       REG_DZ_LOW  = 1'b0;
  localparam logic       REG_DZ_HIGH = 1'b1;

  localparam logic [HW_W-1:0]  MAX_HW_L  = HW_W'(MAX_HALFWORDS);
  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(PAYLOAD_BYTES);

  // Transaction phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR  = 3'd1,
    PH_CMD  = 3'd2,
    PH_HID  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  // One result item
  typedef struct packed {
    logic            tx_valid;
    logic [7:0]      tx_byte;
    logic            want_ack;
    logic            done_res;
    logic [7:0]      pad_id;
    logic [7:0]      pad_hid;
    logic [HW_W-1:0] word_count;
    logic [15:0]     buttons;
    logic [7:0]      axis_right_x;
    logic [7:0]      axis_right_y;
    logic [7:0]      axis_left_x;
    logic [7:0]      axis_left_y;
  } result_t;

  // Dead zone forces zero, otherwise the sign bit is flipped
  function automatic logic [7:0] shape_axis(input logic [7:0] v,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
    logic [7:0] r;
    if ((v > lo) && (v < hi)) begin
      r = BYTE_ZERO;
    end else begin
      r = v ^ SIGN_FLIP;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/gsps_core.sv @@
// Transaction state and per-item next-state / result logic.
`default_nettype none

module gsps_core
  import gsps_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire logic                 mode_i,
  input  wire logic [7:0]           command_i,
  input  wire logic [PAYLOAD_W-1:0] payload_i,
  input  wire logic [LEN_W-1:0]     payload_len_i,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic [7:0]           dz_low_i,
  input  wire logic [7:0]           dz_high_i,
  output result_t                   res_o
);

  phase_e                 phase_q, phase_d;
  logic [7:0]             cmd_q, cmd_d;
  logic [PAYLOAD_W-1:0]   pay_q, pay_d;
  logic [LEN_W-1:0]       pcnt_q, pcnt_d;
  logic [IDX_W-1:0]       bidx_q, bidx_d;
  logic [HW_W-1:0]        hwt_q, hwt_d;
  logic [7:0]             id_q, id_d;
  logic [7:0]             hid_q, hid_d;
  logic [15:0]            btn_q, btn_d;
  logic [7:0]             axis_q [4];
  logic [7:0]             axis_d [4];
  logic [7:0]             wbuf_q [KEEP_BYTES];
  logic [7:0]             wbuf_d [KEEP_BYTES];

  logic [7:0]             rx_m1;
  logic [HW_W-1:0]        new_hw;
  logic [IDX_W-1:0]       total;
  logic [IDX_W-1:0]       bidx_inc;
  logic [LEN_W-1:0]       len_clip;

  // Payload byte k, or the pad byte once the payload runs out
  function automatic logic [7:0] data_byte(input logic [IDX_W-1:0]     k,
                                           input logic [LEN_W-1:0]     cnt,
                                           input logic [PAYLOAD_W-1:0] pay);
    logic [7:0] r;
    r = BYTE_PAD;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if ((k == IDX_W'(i)) && (k < IDX_W'(cnt))) begin
        r = pay[8*i +: 8];
      end
    end
    return r;
  endfunction

  // Halfword count from the id's low nibble, zero meaning the maximum
  always_comb begin
    rx_m1  = rx_byte_i - 8'd1;
    new_hw = {1'b0, rx_m1[3:0] & COUNT_MASK} + HW_W'(1);
    if (new_hw > MAX_HW_L) begin
      new_hw = MAX_HW_L;
    end
    len_clip = (payload_len_i > MAX_LEN_L) ? MAX_LEN_L : payload_len_i;
    total    = {hwt_q, 1'b0};
    bidx_inc = bidx_q + IDX_W'(1);
  end

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    pay_d   = pay_q;
    pcnt_d  = pcnt_q;
    bidx_d  = bidx_q;
    hwt_d   = hwt_q;
    id_d    = id_q;
    hid_d   = hid_q;
    btn_d   = btn_q;
    for (int a = 0; a < 4; a++) begin
      axis_d[a] = axis_q[a];
    end
    for (int b = 0; b < KEEP_BYTES; b++) begin
      wbuf_d[b] = wbuf_q[b];
    end
    res_o.tx_valid = 1'b0;
    res_o.tx_byte  = BYTE_ZERO;
    res_o.want_ack = 1'b0;
    res_o.done_res = 1'b0;

    if (!mode_i) begin
      // start: latch command and payload, send header
      cmd_d          = command_i;
      pay_d          = payload_i;
      pcnt_d         = len_clip;
      bidx_d         = '0;
      phase_d        = PH_HDR;
      res_o.tx_valid = 1'b1;
      res_o.tx_byte  = BYTE_HEADER;
      res_o.want_ack = 1'b1;
    end else begin
      case (phase_q)
        PH_HDR: begin
          phase_d        = PH_CMD;
          res_o.tx_valid = 1'b1;
          res_o.tx_byte  = cmd_q;
          res_o.want_ack = 1'b1;
        end
        PH_CMD: begin
          id_d           = rx_byte_i;
          hwt_d          = new_hw;
          phase_d        = PH_HID;
          res_o.tx_valid = 1'b1;
          res_o.tx_byte  = BYTE_ZERO;
          res_o.want_ack = 1'b1;
        end
        PH_HID: begin
          hid_d          = rx_byte_i;
          bidx_d         = '0;
          phase_d        = PH_DATA;
          res_o.tx_valid = 1'b1;
          res_o.tx_byte  = data_byte('0, pcnt_q, pay_q);
          res_o.want_ack = (total - IDX_W'(1)) != '0;
        end
        PH_DATA: begin
          // keep only the bytes that feed buttons and axes
          for (int b = 0; b < KEEP_BYTES; b++) begin
            if (bidx_q == IDX_W'(b)) begin
              wbuf_d[b] = rx_byte_i;
            end
          end
          bidx_d = bidx_inc;
          if (bidx_inc >= total) begin
            btn_d = {wbuf_d[1], wbuf_d[0]};
            if (hwt_q >= HW_W'(2)) begin
              axis_d[0] = shape_axis(wbuf_d[2], dz_low_i, dz_high_i);
              axis_d[1] = shape_axis(wbuf_d[3], dz_low_i, dz_high_i);
            end
            if (hwt_q >= HW_W'(3)) begin
              axis_d[2] = shape_axis(wbuf_d[4], dz_low_i, dz_high_i);
              axis_d[3] = shape_axis(wbuf_d[5], dz_low_i, dz_high_i);
            end
            phase_d        = PH_IDLE;
            res_o.done_res = 1'b1;
          end else begin
            res_o.tx_valid = 1'b1;
            res_o.tx_byte  = data_byte(bidx_inc, pcnt_q, pay_q);
            res_o.want_ack = bidx_inc != (total - IDX_W'(1));
          end
        end
        default: begin
          // idle: received bytes are ignored
        end
      endcase
    end

    res_o.pad_id       = id_d;
    res_o.pad_hid      = hid_d;
    res_o.word_count   = hwt_d;
    res_o.buttons      = btn_d;
    res_o.axis_right_x = axis_d[0];
    res_o.axis_right_y = axis_d[1];
    res_o.axis_left_x  = axis_d[2];
    res_o.axis_left_y  = axis_d[3];
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      pay_q   <= '0;
      pcnt_q  <= '0;
      bidx_q  <= '0;
      hwt_q   <= HW_W'(1);
      id_q    <= '0;
      hid_q   <= '0;
      btn_q   <= '0;
      for (int a = 0; a < 4; a++) begin
        axis_q[a] <= '0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      pay_q   <= pay_d;
      pcnt_q  <= pcnt_d;
      bidx_q  <= bidx_d;
      hwt_q   <= hwt_d;
      id_q    <= id_d;
      hid_q   <= hid_d;
      btn_q   <= btn_d;
      for (int a = 0; a < 4; a++) begin
        axis_q[a] <= axis_d[a];
      end
    end
  end

  // Received data bytes, contents undefined until written
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int b = 0; b < KEEP_BYTES; b++) begin
        wbuf_q[b] <= wbuf_d[b];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/gsps_out_reg.sv @@
// Result register with valid/stall handshake toward the receiver.
`default_nettype none

module gsps_out_reg
  import gsps_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    out_stall_i,
  output logic         out_valid_o,
  output logic         busy_o,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  // Full and not being taken this cycle
  assign busy_o      = valid_q & out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gamepad_serial_poll_sequencer.sv @@
// Top level of the game-pad poll sequencer: dead-zone registers and wiring.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one item per serial byte. A start
//   item (mode 0) carries command and payload; each later item (mode 1)
//   carries the byte the pad returned for the last byte sent.
//   Output channel (out_valid_o / out_stall_i): exactly one result item per
//   input item, telling which byte to send next, whether an acknowledge is
//   expected, and the current id, count, buttons and axes.
//   The result of an item accepted at one edge is registered and valid after
//   that edge. Throughput is one item per cycle while the receiver does not
//   stall; the single phase update and the result register set that figure.
//   When the receiver stalls, the result holds and in_stall_o rises, so no
//   new item enters until the held result is taken; a result may be taken and
//   the next item accepted at the same edge. Reset sets the phase idle and the
//   dead zone to 96..160 (exclusive). The user must make dead-zone writes via
//   cfg_we_i / cfg_index_i / cfg_data_i only while idle; this is not enforced.
`default_nettype none

module gamepad_serial_poll_sequencer
  import gsps_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_index_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 mode_i,
  input  wire logic [7:0]           command_i,
  input  wire logic [PAYLOAD_W-1:0] payload_i,
  input  wire logic [LEN_W-1:0]     payload_len_i,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      tx_valid_o,
  output logic [7:0]                tx_byte_o,
  output logic                      want_ack_o,
  output logic                      done_res_o,
  output logic [7:0]                pad_id_o,
  output logic [7:0]                pad_hid_o,
  output logic [HW_W-1:0]           word_count_o,
  output logic [15:0]               buttons_o,
  output logic [7:0]                axis_right_x_o,
  output logic [7:0]                axis_right_y_o,
  output logic [7:0]                axis_left_x_o,
  output logic [7:0]                axis_left_y_o
);

  logic [7:0] dz_low_q;
  logic [7:0] dz_high_q;
  logic       fire;
  logic       busy;
  result_t    res_d;
  result_t    res_q;

  // Dead-zone registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_low_q  <= DZ_LOW_RST;
      dz_high_q <= DZ_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DZ_LOW:  dz_low_q  <= cfg_data_i;
        REG_DZ_HIGH: dz_high_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input handshake
  assign in_stall_o = busy;
  assign fire       = in_valid_i & ~busy;

  gsps_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .mode_i        (mode_i),
    .command_i     (command_i),
    .payload_i     (payload_i),
    .payload_len_i (payload_len_i),
    .rx_byte_i     (rx_byte_i),
    .dz_low_i      (dz_low_q),
    .dz_high_i     (dz_high_q),
    .res_o         (res_d)
  );

  gsps_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (busy),
    .res_o       (res_q)
  );

  // Result fields
  assign tx_valid_o     = res_q.tx_valid;
  assign tx_byte_o      = res_q.tx_byte;
  assign want_ack_o     = res_q.want_ack;
  assign done_res_o     = res_q.done_res;
  assign pad_id_o       = res_q.pad_id;
  assign pad_hid_o      = res_q.pad_hid;
  assign word_count_o   = res_q.word_count;
  assign buttons_o      = res_q.buttons;
  assign axis_right_x_o = res_q.axis_right_x;
  assign axis_right_y_o = res_q.axis_right_y;
  assign axis_left_x_o  = res_q.axis_left_x;
  assign axis_left_y_o  = res_q.axis_left_y;

endmodule

`default_nettype wire
